>>> rtl/core/mmrd_pkg.sv
package mmrd_pkg;

    localparam int unsigned MAX_QUANTITY = 2000;
    localparam int unsigned QTY_W = 11;
    localparam logic [7:0] POS_LIMIT = 8'd255;

    localparam logic [3:0] KIND_COIL_VALUE  = 4'd0;
    localparam logic [3:0] KIND_DIN_VALUE   = 4'd1;
    localparam logic [3:0] KIND_INREG_VALUE = 4'd2;
    localparam logic [3:0] KIND_HREG_VALUE  = 4'd3;
    localparam logic [3:0] KIND_COIL_WRITE  = 4'd4;
    localparam logic [3:0] KIND_HREG_WRITE  = 4'd5;
    localparam logic [3:0] KIND_EXC_COIL    = 4'd6;
    localparam logic [3:0] KIND_EXC_DIN     = 4'd7;
    localparam logic [3:0] KIND_EXC_HREG    = 4'd8;
    localparam logic [3:0] KIND_EXC_INREG   = 4'd9;
    localparam logic [3:0] KIND_ERROR       = 4'd10;

    localparam logic [7:0] FC_READ_COILS   = 8'd1;
    localparam logic [7:0] FC_READ_DIN     = 8'd2;
    localparam logic [7:0] FC_READ_HREGS   = 8'd3;
    localparam logic [7:0] FC_READ_INREGS  = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
    localparam logic [7:0] FC_WRITE_HREG   = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS  = 8'd15;
    localparam logic [7:0] FC_WRITE_HREGS  = 8'd16;

    function automatic logic is_write_fc(input logic [7:0] f);
        return (f == FC_WRITE_COIL) || (f == FC_WRITE_HREG) ||
               (f == FC_WRITE_COILS) || (f == FC_WRITE_HREGS);
    endfunction

    function automatic logic is_read_fc(input logic [7:0] f);
        return (f == FC_READ_COILS) || (f == FC_READ_DIN) ||
               (f == FC_READ_HREGS) || (f == FC_READ_INREGS);
    endfunction

    function automatic logic [3:0] exception_kind(input logic [6:0] ff);
        logic [7:0] f;
        f = {1'b0, ff};
        if (f == FC_READ_COILS || f == FC_WRITE_COIL || f == FC_WRITE_COILS)
            return KIND_EXC_COIL;
        else if (f == FC_READ_DIN)
            return KIND_EXC_DIN;
        else if (f == FC_READ_HREGS || f == FC_WRITE_HREG || f == FC_WRITE_HREGS)
            return KIND_EXC_HREG;
        else if (f == FC_READ_INREGS)
            return KIND_EXC_INREG;
        else
            return KIND_ERROR;
    endfunction

endpackage

>>> rtl/core/modbus_master_response_decoder.sv
// Modbus RTU master response decoder.
// The input channel (in_valid/in_ready) carries one response byte per word,
// with frame_start on the first byte of a frame and the function, start
// address and quantity of the outstanding request. The output channel
// (out_valid/out_ready) carries decoded results, one per word, with
// last_of_run set on the final result caused by an input byte.
// A byte that causes a single result is registered into the single-result
// state, which loads it into the output register once that is free; a coil or
// discrete-input data byte emits up to eight results, one per cycle while the
// receiver keeps up, from a sequencer that walks the bits through one shift
// register and one address adder. The block takes the next byte once the last
// result of the current byte is loaded into the output register. A byte that
// causes no result leaves the block ready for the next byte.
// When the receiver stalls, the output register holds its word and the
// sequencer waits; no result is dropped.
// Reset clears the frame position, object count, held unit id, held
// function, exception flag and held high byte, and empties the output.
module modbus_master_response_decoder
    import mmrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    input  logic             frame_start,
    input  logic [7:0]       request_function,
    input  logic [15:0]      request_address,
    input  logic [QTY_W-1:0] request_quantity,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [3:0]       result_kind,
    output logic [7:0]       unit_id,
    output logic [15:0]      object_address,
    output logic [15:0]      result_value,
    output logic [6:0]       failed_function,
    output logic             last_of_run
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ONE  = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [7:0]       byte_position_reg, byte_position_next;
    logic [QTY_W-1:0] objects_done_reg, objects_done_next;
    logic [7:0]       held_unit_id_reg, held_unit_id_next;
    logic [7:0]       held_function_reg, held_function_next;
    logic             exception_mode_reg, exception_mode_next;
    logic [7:0]       high_byte_hold_reg, high_byte_hold_next;

    logic [3:0]       kind_reg, kind_next;
    logic [15:0]      adr_reg, adr_next;
    logic [15:0]      run_value_reg, run_value_next;
    logic [6:0]       ff_reg, ff_next;
    logic [QTY_W-1:0] limit_reg, limit_next;
    logic [3:0]       bits_left_reg, bits_left_next;
    logic             bit_mode_reg, bit_mode_next;

    logic             out_valid_reg, out_valid_next;
    logic [3:0]       out_kind_reg, out_kind_next;
    logic [7:0]       out_sid_reg, out_sid_next;
    logic [15:0]      out_addr_reg, out_addr_next;
    logic [15:0]      out_value_reg, out_value_next;
    logic [6:0]       out_ff_reg, out_ff_next;
    logic             out_last_reg, out_last_next;

    logic             accept;
    logic             out_free;
    logic [7:0]       pos;
    logic [QTY_W-1:0] limit_in;
    logic [QTY_W-1:0] done_inc;
    logic [3:0]       exc_kind;
    logic             run_last;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign pos      = frame_start ? 8'd0 : byte_position_reg;
    assign limit_in = (request_quantity < QTY_W'(MAX_QUANTITY)) ?
                      request_quantity : QTY_W'(MAX_QUANTITY);
    assign done_inc = objects_done_reg + 1'b1;
    assign exc_kind = exception_kind(held_function_reg[6:0]);
    assign run_last = (bits_left_reg == 4'd1) || (done_inc == limit_reg);

    always_comb
    begin
        state_next          = state_reg;
        byte_position_next  = byte_position_reg;
        objects_done_next   = objects_done_reg;
        held_unit_id_next   = held_unit_id_reg;
        held_function_next  = held_function_reg;
        exception_mode_next = exception_mode_reg;
        high_byte_hold_next = high_byte_hold_reg;
        kind_next           = kind_reg;
        adr_next            = adr_reg;
        run_value_next      = run_value_reg;
        ff_next             = ff_reg;
        limit_next          = limit_reg;
        bits_left_next      = bits_left_reg;
        bit_mode_next       = bit_mode_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        out_kind_next       = out_kind_reg;
        out_sid_next        = out_sid_reg;
        out_addr_next       = out_addr_reg;
        out_value_next      = out_value_reg;
        out_ff_next         = out_ff_reg;
        out_last_next       = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && pos != POS_LIMIT)
                begin
                    byte_position_next = pos + 8'd1;
                    adr_next           = request_address;
                    limit_next         = limit_in;
                    ff_next            = 7'd0;
                    if (pos == 8'd0)
                    begin
                        held_unit_id_next   = rx_byte;
                        exception_mode_next = 1'b0;
                        objects_done_next   = '0;
                        high_byte_hold_next = 8'd0;
                    end
                    else if (pos == 8'd1)
                    begin
                        held_function_next  = rx_byte;
                        objects_done_next   = '0;
                        exception_mode_next = rx_byte[7];
                        if (!rx_byte[7])
                        begin
                            if (is_write_fc(request_function))
                            begin
                                state_next = S_ONE;
                                if (rx_byte == FC_WRITE_COIL)
                                begin
                                    kind_next      = KIND_COIL_WRITE;
                                    run_value_next = 16'd1;
                                end
                                else if (rx_byte == FC_WRITE_HREG)
                                begin
                                    kind_next      = KIND_HREG_WRITE;
                                    run_value_next = 16'd1;
                                end
                                else if (rx_byte == FC_WRITE_COILS)
                                begin
                                    kind_next      = KIND_COIL_WRITE;
                                    run_value_next = 16'(request_quantity);
                                end
                                else
                                begin
                                    kind_next      = KIND_HREG_WRITE;
                                    run_value_next = 16'(request_quantity);
                                end
                            end
                            else if (!is_read_fc(request_function))
                            begin
                                state_next     = S_ONE;
                                kind_next      = KIND_ERROR;
                                run_value_next = 16'd0;
                            end
                        end
                    end
                    else if (exception_mode_reg)
                    begin
                        if (pos == 8'd2)
                        begin
                            state_next     = S_ONE;
                            kind_next      = exc_kind;
                            ff_next        = held_function_reg[6:0];
                            run_value_next = (exc_kind == KIND_ERROR) ? 16'd0 :
                                             {8'd0, rx_byte};
                        end
                    end
                    else if (pos >= 8'd3 && is_read_fc(request_function))
                    begin
                        if (held_function_reg == FC_READ_COILS ||
                            held_function_reg == FC_READ_DIN)
                        begin
                            if (objects_done_reg < limit_in)
                            begin
                                state_next     = S_RUN;
                                bit_mode_next  = 1'b1;
                                bits_left_next = 4'd8;
                                run_value_next = {8'd0, rx_byte};
                                kind_next      = (held_function_reg == FC_READ_COILS) ?
                                                 KIND_COIL_VALUE : KIND_DIN_VALUE;
                            end
                        end
                        else if (held_function_reg == FC_READ_HREGS ||
                                 held_function_reg == FC_READ_INREGS)
                        begin
                            if (pos[0])
                                high_byte_hold_next = rx_byte;
                            else if (objects_done_reg < limit_in)
                            begin
                                state_next     = S_RUN;
                                bit_mode_next  = 1'b0;
                                bits_left_next = 4'd1;
                                run_value_next = {high_byte_hold_reg, rx_byte};
                                kind_next      = (held_function_reg == FC_READ_INREGS) ?
                                                 KIND_INREG_VALUE : KIND_HREG_VALUE;
                            end
                        end
                    end
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_sid_next   = held_unit_id_reg;
                    out_addr_next  = adr_reg;
                    out_value_next = run_value_reg;
                    out_ff_next    = ff_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RUN:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_kind_next     = kind_reg;
                    out_sid_next      = held_unit_id_reg;
                    out_addr_next     = adr_reg + 16'(objects_done_reg);
                    out_value_next    = bit_mode_reg ? {15'd0, run_value_reg[0]} :
                                        run_value_reg;
                    out_ff_next       = 7'd0;
                    out_last_next     = run_last;
                    objects_done_next = done_inc;
                    run_value_next    = {1'b0, run_value_reg[15:1]};
                    bits_left_next    = bits_left_reg - 4'd1;
                    if (run_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            byte_position_reg  <= 8'd0;
            objects_done_reg   <= '0;
            held_unit_id_reg   <= 8'd0;
            held_function_reg  <= 8'd0;
            exception_mode_reg <= 1'b0;
            high_byte_hold_reg <= 8'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            byte_position_reg  <= byte_position_next;
            objects_done_reg   <= objects_done_next;
            held_unit_id_reg   <= held_unit_id_next;
            held_function_reg  <= held_function_next;
            exception_mode_reg <= exception_mode_next;
            high_byte_hold_reg <= high_byte_hold_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        adr_reg       <= adr_next;
        run_value_reg <= run_value_next;
        ff_reg        <= ff_next;
        limit_reg     <= limit_next;
        bits_left_reg <= bits_left_next;
        bit_mode_reg  <= bit_mode_next;
        out_kind_reg  <= out_kind_next;
        out_sid_reg   <= out_sid_next;
        out_addr_reg  <= out_addr_next;
        out_value_reg <= out_value_next;
        out_ff_reg    <= out_ff_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = out_kind_reg;
    assign unit_id         = out_sid_reg;
    assign object_address  = out_addr_reg;
    assign result_value    = out_value_reg;
    assign failed_function = out_ff_reg;
    assign last_of_run     = out_last_reg;

    // A single result is always the last of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ONE && out_free) |=> (out_valid && last_of_run))
        else $error("single result not marked last");

    // The run sequencer never runs past its bit count or the quantity limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (bits_left_reg != 4'd0 &&
                                  objects_done_reg < limit_reg))
        else $error("run sequencer out of bounds");

    // The object count never exceeds the largest quantity.
    assert property (@(posedge clk) disable iff (!rst_n)
        objects_done_reg <= QTY_W'(MAX_QUANTITY))
        else $error("object count overflow");

    // A byte accepted below the position limit and without frame_start advances the frame position by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !frame_start && byte_position_reg != POS_LIMIT) |=>
        (byte_position_reg == $past(byte_position_reg) + 8'd1))
        else $error("frame position did not advance");

endmodule

>>> bench/mmrd_decode_checker.sv
`timescale 1ns / 100ps

module mmrd_decode_checker
    import mmrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [7:0]       rx_byte,
    input  logic             frame_start,
    input  logic [7:0]       request_function,
    input  logic [15:0]      request_address,
    input  logic [QTY_W-1:0] request_quantity,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [3:0]       result_kind,
    input  logic [7:0]       unit_id,
    input  logic [15:0]      object_address,
    input  logic [15:0]      result_value,
    input  logic [6:0]       failed_function,
    input  logic             last_of_run,
    output int               fail_count,
    output int               pending,
    output int               result_total
);

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  sid;
        logic [15:0] addr;
        logic [15:0] value;
        logic [6:0]  ff;
        logic        last;
    } result_t;

    result_t expected_results[$];

    logic [7:0]       frame_pos;
    logic [QTY_W-1:0] objects_done;
    logic [7:0]       held_slave;
    logic [7:0]       held_fn;
    logic             exc_mode;
    logic [7:0]       high_hold;

    function automatic bit is_write_req(input logic [7:0] f);
        return f == FC_WRITE_COIL || f == FC_WRITE_HREG ||
               f == FC_WRITE_COILS || f == FC_WRITE_HREGS;
    endfunction

    function automatic bit is_read_req(input logic [7:0] f);
        return f >= FC_READ_COILS && f <= FC_READ_INREGS;
    endfunction

    function automatic result_t make_result(input logic [3:0] kind, input logic [15:0] addr,
                                            input logic [15:0] value, input logic [6:0] ff);
        result_t r;
        r.kind = kind;
        r.sid = held_slave;
        r.addr = addr;
        r.value = value;
        r.ff = ff;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
        fail_count++;
    endtask

    task automatic predict_response_byte(input logic [7:0] b, input logic start,
                                         input logic [7:0] rf, input logic [15:0] adr,
                                         input logic [QTY_W-1:0] qty);
        result_t          batch[$];
        logic [QTY_W-1:0] lim;
        logic [7:0]       pos;
        logic [6:0]       ff;
        logic [3:0]       k;
        int               i;
        lim = (qty < MAX_QUANTITY) ? qty : QTY_W'(MAX_QUANTITY);
        if (start)
            frame_pos = 8'd0;
        pos = frame_pos;
        if (pos != POS_LIMIT)
        begin
            if (pos == 8'd0)
            begin
                held_slave = b;
                exc_mode = 1'b0;
                objects_done = '0;
                high_hold = 8'd0;
            end
            else if (pos == 8'd1)
            begin
                held_fn = b;
                objects_done = '0;
                exc_mode = b[7];
                if (!exc_mode)
                begin
                    if (is_write_req(rf))
                    begin
                        case (b)
                            FC_WRITE_COIL:  batch.push_back(make_result(KIND_COIL_WRITE, adr,
                                                                        16'd1, 7'd0));
                            FC_WRITE_HREG:  batch.push_back(make_result(KIND_HREG_WRITE, adr,
                                                                        16'd1, 7'd0));
                            FC_WRITE_COILS: batch.push_back(make_result(KIND_COIL_WRITE, adr,
                                                                        16'(qty), 7'd0));
                            default:        batch.push_back(make_result(KIND_HREG_WRITE, adr,
                                                                        16'(qty), 7'd0));
                        endcase
                    end
                    else if (!is_read_req(rf))
                        batch.push_back(make_result(KIND_ERROR, adr, 16'd0, 7'd0));
                end
            end
            else if (exc_mode)
            begin
                if (pos == 8'd2)
                begin
                    ff = held_fn[6:0];
                    case ({1'b0, ff}) inside
                        FC_READ_COILS, FC_WRITE_COIL, FC_WRITE_COILS: k = KIND_EXC_COIL;
                        FC_READ_DIN:                                  k = KIND_EXC_DIN;
                        FC_READ_HREGS, FC_WRITE_HREG, FC_WRITE_HREGS: k = KIND_EXC_HREG;
                        FC_READ_INREGS:                               k = KIND_EXC_INREG;
                        default:                                      k = KIND_ERROR;
                    endcase
                    batch.push_back(make_result(k, adr, (k == KIND_ERROR) ? 16'd0 : 16'(b),
                                                ff));
                end
            end
            else if (pos >= 8'd3 && is_read_req(rf))
            begin
                if (held_fn == FC_READ_COILS || held_fn == FC_READ_DIN)
                begin
                    for (i = 0; i < 8 && objects_done < lim; i++)
                    begin
                        batch.push_back(make_result(
                            (held_fn == FC_READ_COILS) ? KIND_COIL_VALUE : KIND_DIN_VALUE,
                            adr + 16'(objects_done), 16'(b[i]), 7'd0));
                        objects_done++;
                    end
                end
                else if (held_fn == FC_READ_HREGS || held_fn == FC_READ_INREGS)
                begin
                    if (pos[0])
                        high_hold = b;
                    else if (objects_done < lim)
                    begin
                        batch.push_back(make_result(
                            (held_fn == FC_READ_INREGS) ? KIND_INREG_VALUE : KIND_HREG_VALUE,
                            adr + 16'(objects_done), {high_hold, b}, 7'd0));
                        objects_done++;
                    end
                end
            end
            frame_pos = pos + 8'd1;
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[j])
                expected_results.push_back(batch[j]);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            frame_pos = 8'd0;
            objects_done = '0;
            held_slave = 8'd0;
            held_fn = 8'd0;
            exc_mode = 1'b0;
            high_hold = 8'd0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_total++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result word, kind", 0, 32'(result_kind));
                else
                begin
                    want = expected_results.pop_front();
                    if (result_kind != want.kind)
                        report_mismatch("result_kind", 32'(want.kind), 32'(result_kind));
                    if (unit_id != want.sid)
                        report_mismatch("unit_id", 32'(want.sid), 32'(unit_id));
                    if (object_address != want.addr)
                        report_mismatch("object_address", 32'(want.addr),
                                        32'(object_address));
                    if (result_value != want.value)
                        report_mismatch("result_value", 32'(want.value), 32'(result_value));
                    if (failed_function != want.ff)
                        report_mismatch("failed_function", 32'(want.ff),
                                        32'(failed_function));
                    if (last_of_run != want.last)
                        report_mismatch("last_of_run", 32'(want.last), 32'(last_of_run));
                end
            end
            if (in_valid && in_ready)
                predict_response_byte(rx_byte, frame_start, request_function,
                                      request_address, request_quantity);
        end
        pending = expected_results.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mmrd_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       rx_byte;
    logic             frame_start;
    logic [7:0]       request_function;
    logic [15:0]      request_address;
    logic [QTY_W-1:0] request_quantity;
    logic             out_valid;
    logic             out_ready;
    logic [3:0]       result_kind;
    logic [7:0]       unit_id;
    logic [15:0]      object_address;
    logic [15:0]      result_value;
    logic [6:0]       failed_function;
    logic             last_of_run;

    int fail_count;
    int pending;
    int result_total;
    int bytes_sent;
    int frames_sent;
    bit calm;

    modbus_master_response_decoder dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .frame_start      (frame_start),
        .request_function (request_function),
        .request_address  (request_address),
        .request_quantity (request_quantity),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .unit_id          (unit_id),
        .object_address   (object_address),
        .result_value     (result_value),
        .failed_function  (failed_function),
        .last_of_run      (last_of_run)
    );

    mmrd_decode_checker decode_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .frame_start      (frame_start),
        .request_function (request_function),
        .request_address  (request_address),
        .request_quantity (request_quantity),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .unit_id          (unit_id),
        .object_address   (object_address),
        .result_value     (result_value),
        .failed_function  (failed_function),
        .last_of_run      (last_of_run),
        .fail_count       (fail_count),
        .pending          (pending),
        .result_total     (result_total)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 8);

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic start, input logic [7:0] rf,
                             input logic [15:0] adr, input logic [QTY_W-1:0] qty);
        if (!calm && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        frame_start <= start;
        request_function <= rf;
        request_address <= adr;
        request_quantity <= qty;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic send_random_frame();
        logic [7:0]       rf;
        logic [7:0]       fn;
        logic [15:0]      adr;
        logic [QTY_W-1:0] qty;
        logic             start;
        int               sel;
        int               capped;
        int               dcount;
        int               i;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            rf = 8'($urandom_range(1, 4));
        else if (sel < 80)
        begin
            case ($urandom_range(0, 3))
                0: rf = FC_WRITE_COIL;
                1: rf = FC_WRITE_HREG;
                2: rf = FC_WRITE_COILS;
                default: rf = FC_WRITE_HREGS;
            endcase
        end
        else
            rf = 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (sel < 75)
            fn = rf;
        else if (sel < 88)
            fn = rf | 8'h80;
        else
            fn = 8'($urandom_range(0, 255));
        qty = ($urandom_range(0, 99) < 85) ? QTY_W'($urandom_range(0, 24))
                                           : QTY_W'($urandom_range(0, 2047));
        adr = ($urandom_range(0, 99) < 20) ? 16'hFFF0 + 16'($urandom_range(0, 15))
                                           : 16'($urandom_range(0, 65535));
        capped = (qty > 40) ? 40 : qty;
        if (rf == FC_READ_COILS || rf == FC_READ_DIN)
            dcount = (capped + 7) / 8;
        else if (rf == FC_READ_HREGS || rf == FC_READ_INREGS)
            dcount = 2 * ((capped > 10) ? 10 : capped);
        else
            dcount = 4;
        if (fn[7])
            dcount = 0;
        dcount += $urandom_range(0, 2);
        for (i = 0; i < dcount + 5; i++)
        begin
            if (i == 0)
                start = ($urandom_range(0, 99) < 95);
            else
                start = ($urandom_range(0, 99) < 3);
            if (i > 0 && $urandom_range(0, 99) < 3)
                adr = 16'($urandom_range(0, 65535));
            send_byte((i == 1) ? fn : 8'($urandom_range(0, 255)), start, rf, adr, qty);
        end
        frames_sent++;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'd0;
        frame_start = 1'b0;
        request_function = 8'd0;
        request_address = 16'd0;
        request_quantity = '0;
        calm = 1'b0;
        bytes_sent = 0;
        frames_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_byte(8'h00, 1'b1, FC_WRITE_COIL, 16'hFFFF, 11'd1);
        send_byte(FC_WRITE_COIL, 1'b0, FC_WRITE_COIL, 16'hFFFF, 11'd1);
        send_byte(8'hAA, 1'b0, FC_WRITE_COIL, 16'hFFFF, 11'd1);
        send_byte(8'hFF, 1'b1, FC_WRITE_HREGS, 16'h0000, 11'd2000);
        send_byte(FC_WRITE_HREGS, 1'b0, FC_WRITE_HREGS, 16'h0000, 11'd2000);
        send_byte(8'h11, 1'b1, FC_WRITE_COILS, 16'h8000, 11'd2047);
        send_byte(FC_WRITE_COILS, 1'b0, FC_WRITE_COILS, 16'h8000, 11'd2047);
        send_byte(8'h12, 1'b1, FC_WRITE_HREG, 16'h0040, 11'd1);
        send_byte(FC_WRITE_HREG, 1'b0, FC_WRITE_HREG, 16'h0040, 11'd1);
        send_byte(8'h13, 1'b1, 8'hFF, 16'h5555, 11'd7);
        send_byte(8'h42, 1'b0, 8'hFF, 16'h5555, 11'd7);
        send_byte(8'h14, 1'b1, FC_READ_HREGS, 16'h0100, 11'd5);
        send_byte(8'h83, 1'b0, FC_READ_HREGS, 16'h0100, 11'd5);
        send_byte(8'h02, 1'b0, FC_READ_HREGS, 16'h0100, 11'd5);
        send_byte(8'h15, 1'b1, FC_READ_INREGS, 16'h2222, 11'd3);
        send_byte(8'hFF, 1'b0, FC_READ_INREGS, 16'h2222, 11'd3);
        send_byte(8'hFF, 1'b0, FC_READ_INREGS, 16'h2222, 11'd3);
        send_byte(8'h16, 1'b1, FC_READ_COILS, 16'hFFFE, 11'd10);
        send_byte(FC_READ_COILS, 1'b0, FC_READ_COILS, 16'hFFFE, 11'd10);
        send_byte(8'h02, 1'b0, FC_READ_COILS, 16'hFFFE, 11'd10);
        send_byte(8'hA5, 1'b0, FC_READ_COILS, 16'hFFFE, 11'd10);
        send_byte(8'hFF, 1'b0, FC_READ_COILS, 16'hFFFE, 11'd10);
        send_byte(8'h17, 1'b1, FC_READ_INREGS, 16'h1234, 11'd1);
        send_byte(FC_READ_INREGS, 1'b0, FC_READ_INREGS, 16'h1234, 11'd1);
        send_byte(8'h02, 1'b0, FC_READ_INREGS, 16'h1234, 11'd1);
        send_byte(8'hFF, 1'b0, FC_READ_INREGS, 16'h1234, 11'd1);
        send_byte(8'hEE, 1'b0, FC_READ_INREGS, 16'h1234, 11'd1);
        frames_sent += 9;
        drain_results();

        while (bytes_sent < 122)
        begin
            calm = (frames_sent >= 11 && frames_sent < 15);
            send_random_frame();
            if ($urandom_range(0, 99) < 10)
                drain_results();
        end
        calm = 1'b0;

        drain_results();
        repeat (20) @(negedge clk);
        $display("Sent %0d response bytes in %0d frames: writes, reads, exceptions, noise.",
                 bytes_sent, frames_sent);
        $display("Compared %0d result words with the prediction.", result_total);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/mmrd_pkg.sv
rtl/core/modbus_master_response_decoder.sv
bench/mmrd_decode_checker.sv
bench/testbench.sv
